@@ rtl/gnmc_pkg.sv @@
// Package for the grid neighbor match counter.
// Holds field widths, register indexes, the neighborhood mode, the flag struct and the size clamp function.
// No dependencies.
package gnmc_pkg;

    localparam int VALUE_W    = 16;
    localparam int SIZE_CFG_W = 11;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int IN_ROW_W   = 11;
    localparam int OUT_POS_W  = 10;
    localparam int COUNT_W    = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_COLS = 2'd0,
        CFG_GRID_ROWS = 2'd1,
        CFG_TARGET    = 2'd2,
        CFG_MODE      = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        MODE_MOORE       = 1'b0,
        MODE_VON_NEUMANN = 1'b1
    } t_nbr_mode;

    typedef struct packed {
        logic emit;
        logic last;
        logic cur;
        logic has_left;
        logic has_right;
        logic has_up;
        logic has_down;
    } t_nbr_flags;

    function automatic logic [31:0] clamp_size(logic [SIZE_CFG_W-1:0] v, int unsigned maxv);
        logic [31:0] w;
        w = 32'(v);
        if (w == 32'd0) begin
            return 32'd1;
        end
        if (w > maxv) begin
            return maxv;
        end
        return w;
    endfunction

endpackage

@@ rtl/grid_neighbor_match_count_top.sv @@
// Top level of the grid neighbor match counter.
// Uses gnmc_pkg, gnmc_ctrl, gnmc_stencil and gnmc_ram.
//
// The block takes one grid cell per clock in raster order and returns, per cell, the number
// of Moore or von Neumann neighbors equal to the target value. A result comes out on the
// word that lies grid_cols+1 words after its cell, so grid_cols+1 drain words flush a frame.
// Each word passes through the position logic and then the history stage, where
// a two-bit line buffer RAM holding the last two rows is read and written back; the result
// then sits in an output register. The sustained rate is one word per cycle and is limited
// only by output backpressure. No clearing pass is needed after reset.
module grid_neighbor_match_count_top import gnmc_pkg::*; #(
    parameter int MAX_COLS  = 1024,
    parameter int MAX_ROWS  = 1024,
    parameter int CELL_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_drain,
    input  logic [VALUE_W-1:0]    i_cell_value,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [OUT_POS_W-1:0]  o_out_col,
    output logic [OUT_POS_W-1:0]  o_out_row,
    output logic [COUNT_W-1:0]    o_match_count,
    output logic                  o_frame_last
);

    localparam int COL_W = $clog2(MAX_COLS);
    localparam int ROW_W = $clog2(MAX_ROWS);

    logic             in_acc;
    t_nbr_mode        mode;
    t_nbr_flags       flags;
    logic [COL_W-1:0] addr;
    logic [COL_W-1:0] res_col;
    logic [ROW_W-1:0] res_row;

    assign in_acc = i_in_valid && o_in_ready;

    gnmc_ctrl #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS),
        .CELL_BITS(CELL_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (in_acc),
        .i_drain     (i_drain),
        .i_cell_value(i_cell_value),
        .o_mode      (mode),
        .o_flags     (flags),
        .o_addr      (addr),
        .o_res_col   (res_col),
        .o_res_row   (res_row)
    );

    gnmc_stencil #(
        .MAX_COLS(MAX_COLS),
        .MAX_ROWS(MAX_ROWS)
    ) u_stencil (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_acc),
        .i_flags      (flags),
        .i_addr       (addr),
        .i_res_col    (res_col),
        .i_res_row    (res_row),
        .i_mode       (mode),
        .i_out_ready  (i_out_ready),
        .o_in_ready   (o_in_ready),
        .o_out_valid  (o_out_valid),
        .o_out_col    (o_out_col),
        .o_out_row    (o_out_row),
        .o_match_count(o_match_count),
        .o_frame_last (o_frame_last)
    );

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_match_count <= COUNT_W'(8)))
        else $error("match count above eight");

    a_vn_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (mode == MODE_VON_NEUMANN)) |-> (o_match_count <= COUNT_W'(4)))
        else $error("von Neumann count above four");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready))
        else $error("input stalled without output backpressure");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule

@@ rtl/gnmc_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module gnmc_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/gnmc_ctrl.sv @@
// Configuration registers and raster position counters of the match counter.
// Computes the match bit and neighbor flags of each accepted word; uses gnmc_pkg.
module gnmc_ctrl import gnmc_pkg::*; #(
    parameter int MAX_COLS  = 1024,
    parameter int MAX_ROWS  = 1024,
    parameter int CELL_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [CFG_DATA_W-1:0]         i_cfg_wdata,
    input  logic                          i_accept,
    input  logic                          i_drain,
    input  logic [VALUE_W-1:0]            i_cell_value,
    output t_nbr_mode                     o_mode,
    output t_nbr_flags                    o_flags,
    output logic [$clog2(MAX_COLS)-1:0]   o_addr,
    output logic [$clog2(MAX_COLS)-1:0]   o_res_col,
    output logic [$clog2(MAX_ROWS)-1:0]   o_res_row
);

    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int COLS_W   = $clog2(MAX_COLS + 1);
    localparam int ROWS_W   = $clog2(MAX_ROWS + 1);
    localparam int CMP_BITS = (CELL_BITS < VALUE_W) ? CELL_BITS : VALUE_W;

    logic [COLS_W-1:0]   r_cols;
    logic [ROWS_W-1:0]   r_rows;
    logic [VALUE_W-1:0]  r_target;
    t_nbr_mode           r_mode;
    logic [COL_W-1:0]    r_in_col,  n_in_col;
    logic [IN_ROW_W-1:0] r_in_row,  n_in_row;
    logic [COL_W-1:0]    r_res_col, n_res_col;
    logic [ROW_W-1:0]    r_res_row, n_res_row;

    logic [31:0] cols_i, rows_i;
    logic        col_wrap, res_wrap;
    t_nbr_flags  flags;

    always_comb begin
        cols_i   = 32'(r_cols);
        rows_i   = 32'(r_rows);
        col_wrap = (32'(r_in_col) + 32'd1 >= cols_i);
        res_wrap = (32'(r_res_col) + 32'd1 >= cols_i);

        flags.cur = !i_drain && (32'(r_in_row) < rows_i) &&
                    (i_cell_value[CMP_BITS-1:0] == r_target[CMP_BITS-1:0]);
        flags.emit = (r_in_row >= IN_ROW_W'(2)) ||
                     ((r_in_row == IN_ROW_W'(1)) && (r_in_col != '0));
        flags.last = flags.emit && res_wrap && (32'(r_res_row) + 32'd1 == rows_i);
        flags.has_left  = (r_res_col != '0);
        flags.has_right = (32'(r_res_col) + 32'd1 < cols_i);
        flags.has_up    = (r_res_row != '0);
        flags.has_down  = (32'(r_res_row) + 32'd1 < rows_i);

        n_in_col  = col_wrap ? '0 : r_in_col + 1'b1;
        n_in_row  = (col_wrap && (r_in_row != '1)) ? r_in_row + 1'b1 : r_in_row;
        n_res_col = r_res_col;
        n_res_row = r_res_row;
        if (flags.last) begin
            n_in_col  = '0;
            n_in_row  = '0;
            n_res_col = '0;
            n_res_row = '0;
        end else if (flags.emit) begin
            n_res_col = res_wrap ? '0 : r_res_col + 1'b1;
            n_res_row = res_wrap ? r_res_row + 1'b1 : r_res_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols    <= COLS_W'(1);
            r_rows    <= ROWS_W'(1);
            r_target  <= '0;
            r_mode    <= MODE_MOORE;
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_res_col <= '0;
            r_res_row <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_GRID_COLS: begin
                    r_cols    <= COLS_W'(clamp_size(i_cfg_wdata[SIZE_CFG_W-1:0], MAX_COLS));
                    r_in_col  <= '0;
                    r_in_row  <= '0;
                    r_res_col <= '0;
                    r_res_row <= '0;
                end
                CFG_GRID_ROWS: begin
                    r_rows    <= ROWS_W'(clamp_size(i_cfg_wdata[SIZE_CFG_W-1:0], MAX_ROWS));
                    r_in_col  <= '0;
                    r_in_row  <= '0;
                    r_res_col <= '0;
                    r_res_row <= '0;
                end
                CFG_TARGET: begin
                    r_target <= i_cfg_wdata[VALUE_W-1:0];
                end
                CFG_MODE: begin
                    r_mode <= t_nbr_mode'(i_cfg_wdata[0]);
                end
            endcase
        end else if (i_accept) begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_res_col <= n_res_col;
            r_res_row <= n_res_row;
        end
    end

    assign o_mode    = r_mode;
    assign o_flags   = flags;
    assign o_addr    = r_in_col;
    assign o_res_col = r_res_col;
    assign o_res_row = r_res_row;

endmodule

@@ rtl/gnmc_stencil.sv @@
// Match history line buffer, neighbor taps and result register of the match counter.
// Uses gnmc_pkg and gnmc_ram.
module gnmc_stencil import gnmc_pkg::*; #(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  t_nbr_flags                  i_flags,
    input  logic [$clog2(MAX_COLS)-1:0] i_addr,
    input  logic [$clog2(MAX_COLS)-1:0] i_res_col,
    input  logic [$clog2(MAX_ROWS)-1:0] i_res_row,
    input  t_nbr_mode                   i_mode,
    input  logic                        i_out_ready,
    output logic                        o_in_ready,
    output logic                        o_out_valid,
    output logic [OUT_POS_W-1:0]        o_out_col,
    output logic [OUT_POS_W-1:0]        o_out_row,
    output logic [COUNT_W-1:0]          o_match_count,
    output logic                        o_frame_last
);

    localparam int COL_W = $clog2(MAX_COLS);
    localparam int ROW_W = $clog2(MAX_ROWS);

    logic             r_s1_valid;
    t_nbr_flags       r_s1_flags;
    logic [COL_W-1:0] r_s1_addr;
    logic [COL_W-1:0] r_s1_col;
    logic [ROW_W-1:0] r_s1_row;
    logic             r_fwd_hit;
    logic [1:0]       r_fwd_bits;
    logic             r_a1, r_a2, r_b1, r_b2, r_c1, r_c2;

    logic                 r_o_valid;
    logic [OUT_POS_W-1:0] r_o_col, r_o_row;
    logic [COUNT_W-1:0]   r_o_count;
    logic                 r_o_last;

    logic               s1_go;
    logic [1:0]         ram_rdata, rd_bits, wr_bits;
    logic               up, down, left, right, ul, ur, dl, dr;
    logic [COUNT_W-1:0] count;
    logic [31:0]        col_ext, row_ext;

    gnmc_ram #(
        .WIDTH(2),
        .DEPTH(MAX_COLS)
    ) u_hist (
        .i_clk  (i_clk),
        .i_we   (s1_go),
        .i_waddr(r_s1_addr),
        .i_wdata(wr_bits),
        .i_re   (i_accept),
        .i_raddr(i_addr),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        s1_go   = r_s1_valid && (!r_s1_flags.emit || !r_o_valid || i_out_ready);
        rd_bits = r_fwd_hit ? r_fwd_bits : ram_rdata;
        wr_bits = {rd_bits[0], r_s1_flags.cur};

        up    = r_c1 & r_s1_flags.has_up;
        left  = r_b2 & r_s1_flags.has_left;
        right = rd_bits[0] & r_s1_flags.has_right;
        down  = r_a1 & r_s1_flags.has_down;
        ul    = r_c2 & r_s1_flags.has_up & r_s1_flags.has_left;
        ur    = rd_bits[1] & r_s1_flags.has_up & r_s1_flags.has_right;
        dl    = r_a2 & r_s1_flags.has_down & r_s1_flags.has_left;
        dr    = r_s1_flags.cur & r_s1_flags.has_down & r_s1_flags.has_right;

        count = COUNT_W'(up) + COUNT_W'(left) + COUNT_W'(right) + COUNT_W'(down);
        if (i_mode == MODE_MOORE) begin
            count = count + COUNT_W'(ul) + COUNT_W'(ur) + COUNT_W'(dl) + COUNT_W'(dr);
        end

        col_ext = 32'(r_s1_col);
        row_ext = 32'(r_s1_row);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (i_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_go && r_s1_flags.emit) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_flags <= i_flags;
            r_s1_addr  <= i_addr;
            r_s1_col   <= i_res_col;
            r_s1_row   <= i_res_row;
            r_fwd_hit  <= s1_go && (r_s1_addr == i_addr);
            r_fwd_bits <= wr_bits;
        end
        if (s1_go) begin
            r_a1 <= r_s1_flags.cur;
            r_a2 <= r_a1;
            r_b1 <= rd_bits[0];
            r_b2 <= r_b1;
            r_c1 <= rd_bits[1];
            r_c2 <= r_c1;
        end
        if (s1_go && r_s1_flags.emit) begin
            r_o_col   <= col_ext[OUT_POS_W-1:0];
            r_o_row   <= row_ext[OUT_POS_W-1:0];
            r_o_count <= count;
            r_o_last  <= r_s1_flags.last;
        end
    end

    assign o_in_ready    = !r_s1_valid || s1_go;
    assign o_out_valid   = r_o_valid;
    assign o_out_col     = r_o_col;
    assign o_out_row     = r_o_row;
    assign o_match_count = r_o_count;
    assign o_frame_last  = r_o_last;

endmodule

@@ bench/grid_neighbor_match_count_top_test.sv @@
// Self-checking testbench for grid_neighbor_match_count_top, the streaming 3x3 neighbor counter.
// A scoreboard class predicts every count from the accepted words and checks each result.
// Depends on gnmc_pkg and the RTL under rtl/.
module grid_neighbor_match_count_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import gnmc_pkg::*;

    localparam int MAX_COLS      = 1024;
    localparam int MAX_ROWS      = 1024;
    localparam int CELL_BITS     = 16;
    localparam int HIST_DEPTH    = 2 * MAX_COLS + 2;
    localparam int IN_ROW_MAX    = (1 << IN_ROW_W) - 1;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_WORDS  = 350;
    localparam int CALM_FROM     = 100;
    localparam int CALM_TO       = 250;
    localparam int IDLE_PCT      = 14;
    localparam int HIGH_W        = CFG_DATA_W - SIZE_CFG_W;
    localparam logic [VALUE_W-1:0] CELL_MASK = VALUE_W'((64'd1 << CELL_BITS) - 1);

    typedef struct packed {
        logic [OUT_POS_W-1:0] col;
        logic [OUT_POS_W-1:0] row;
        logic [COUNT_W-1:0]   count;
        logic                 last;
    } t_stencil_result;

    class match_count_tracker;
        logic [SIZE_CFG_W-1:0] cols_reg;
        logic [SIZE_CFG_W-1:0] rows_reg;
        logic [VALUE_W-1:0]    target;
        t_nbr_mode             mode;
        bit                    history [HIST_DEPTH];
        int                    head;
        int                    in_col;
        int                    in_row;
        int                    res_col;
        int                    res_row;
        t_stencil_result       pending_counts [$];
        int                    errors;
        int                    checked;

        function new();
            cols_reg = 1;
            rows_reg = 1;
            target   = '0;
            mode     = MODE_MOORE;
            head     = 0;
            errors   = 0;
            checked  = 0;
            restart();
        endfunction

        function void restart();
            in_col  = 0;
            in_row  = 0;
            res_col = 0;
            res_row = 0;
        endfunction

        function int size_used(logic [SIZE_CFG_W-1:0] v, int maxv);
            int n;
            n = int'(v);
            if (n == 0) begin
                return 1;
            end
            if (n > maxv) begin
                return maxv;
            end
            return n;
        endfunction

        function int cols_used();
            return size_used(cols_reg, MAX_COLS);
        endfunction

        function int rows_used();
            return size_used(rows_reg, MAX_ROWS);
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_GRID_COLS: begin
                    cols_reg = data[SIZE_CFG_W-1:0];
                    restart();
                end
                CFG_GRID_ROWS: begin
                    rows_reg = data[SIZE_CFG_W-1:0];
                    restart();
                end
                CFG_TARGET: begin
                    target = data[VALUE_W-1:0];
                end
                CFG_MODE: begin
                    mode = t_nbr_mode'(data[0]);
                end
                default: begin
                end
            endcase
        endfunction

        function int neighbor_match(int dc, int dr, int cols, int rows, bit cur);
            int c;
            int r;
            int age;
            c = res_col + dc;
            r = res_row + dr;
            if (c < 0 || c >= cols || r < 0 || r >= rows) begin
                return 0;
            end
            age = cols + 1 - (dr * cols + dc);
            if (age == 0) begin
                return cur;
            end
            if (age < 1 || age > HIST_DEPTH) begin
                return 0;
            end
            return history[(head + age - 1) % HIST_DEPTH];
        endfunction

        function void take_word(logic drain, logic [VALUE_W-1:0] value);
            int              cols;
            int              rows;
            int              count;
            bit              cur;
            bit              emit;
            bit              last;
            t_stencil_result r;
            cols  = cols_used();
            rows  = rows_used();
            count = 0;
            last  = 0;
            cur   = !drain && in_row < rows && ((value & CELL_MASK) == (target & CELL_MASK));
            emit  = (in_row >= 2) || (in_row == 1 && in_col >= 1);
            if (emit) begin
                count = neighbor_match(0, -1, cols, rows, cur) + neighbor_match(-1, 0, cols, rows, cur)
                      + neighbor_match(1, 0, cols, rows, cur) + neighbor_match(0, 1, cols, rows, cur);
                if (mode == MODE_MOORE) begin
                    count += neighbor_match(-1, -1, cols, rows, cur)
                           + neighbor_match(1, -1, cols, rows, cur)
                           + neighbor_match(-1, 1, cols, rows, cur)
                           + neighbor_match(1, 1, cols, rows, cur);
                end
                last = (res_col == cols - 1) && (res_row == rows - 1);
            end
            head = (head + HIST_DEPTH - 1) % HIST_DEPTH;
            history[head] = cur;
            in_col++;
            if (in_col >= cols) begin
                in_col = 0;
                if (in_row < IN_ROW_MAX) begin
                    in_row++;
                end
            end
            if (emit) begin
                r.col   = OUT_POS_W'(res_col);
                r.row   = OUT_POS_W'(res_row);
                r.count = COUNT_W'(count);
                r.last  = last;
                pending_counts.push_back(r);
                if (last) begin
                    restart();
                end else begin
                    res_col++;
                    if (res_col >= cols) begin
                        res_col = 0;
                        res_row++;
                    end
                end
            end
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_count(logic [OUT_POS_W-1:0] col, logic [OUT_POS_W-1:0] row,
                         logic [COUNT_W-1:0] count, logic last);
            t_stencil_result w;
            if (pending_counts.size() == 0) begin
                report_mismatch($sformatf("result col %0d row %0d with none pending", col, row));
                return;
            end
            w = pending_counts.pop_front();
            checked++;
            if (col !== w.col) begin
                report_mismatch($sformatf("out_col %0d, expected %0d", col, w.col));
            end
            if (row !== w.row) begin
                report_mismatch($sformatf("out_row %0d, expected %0d", row, w.row));
            end
            if (count !== w.count) begin
                report_mismatch($sformatf("match_count %0d, expected %0d at col %0d row %0d",
                                          count, w.count, w.col, w.row));
            end
            if (last !== w.last) begin
                report_mismatch($sformatf("frame_last %0b, expected %0b at col %0d row %0d",
                                          last, w.last, w.col, w.row));
            end
        endtask
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic                  i_drain;
    logic [VALUE_W-1:0]    i_cell_value;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [OUT_POS_W-1:0]  o_out_col;
    logic [OUT_POS_W-1:0]  o_out_row;
    logic [COUNT_W-1:0]    o_match_count;
    logic                  o_frame_last;

    match_count_tracker tracker;
    bit calm;
    int words_sent;
    int frames;
    int widest;
    int tallest;

    grid_neighbor_match_count_top #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS),
        .CELL_BITS(CELL_BITS)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_drain      (i_drain),
        .i_cell_value (i_cell_value),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_col    (o_out_col),
        .o_out_row    (o_out_row),
        .o_match_count(o_match_count),
        .o_frame_last (o_frame_last)
    );

    always #5 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            tracker.check_count(o_out_col, o_out_row, o_match_count, o_frame_last);
        end
    end

    task send_word(logic drain, logic [VALUE_W-1:0] value);
        @(negedge i_clk);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_drain      <= drain;
        i_cell_value <= value;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        tracker.take_word(drain, value);
    endtask

    task load_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        tracker.write_reg(idx, data);
    endtask

    task finish_writes();
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (tracker.pending_counts.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function logic [VALUE_W-1:0] cell_pick(int match_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < match_pct) begin
            return tracker.target;
        end
        if (r < match_pct + 10) begin
            return tracker.target ^ (16'h1 << $urandom_range(0, VALUE_W - 1));
        end
        return VALUE_W'($urandom);
    endfunction

    function logic [CFG_DATA_W-1:0] size_pick();
        int r;
        logic [CFG_DATA_W-1:0] v;
        r = $urandom_range(0, 99);
        if (r < 5) begin
            v = '0;
        end else if (r < 80) begin
            v = CFG_DATA_W'($urandom_range(1, 6));
        end else begin
            v = CFG_DATA_W'($urandom_range(7, 24));
        end
        if ($urandom_range(0, 99) < 30) begin
            v[CFG_DATA_W-1:SIZE_CFG_W] = HIGH_W'($urandom);
        end
        return v;
    endfunction

    function logic [CFG_DATA_W-1:0] target_pick();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            return '0;
        end
        if (r < 20) begin
            return '1;
        end
        return CFG_DATA_W'($urandom);
    endfunction

    // A negative stop_words sends the whole frame followed by its flush words.
    task run_frame(int stop_words, int match_pct, bit pause);
        int cols;
        int rows;
        int cells;
        int total;
        int pause_at;
        logic drain;
        cols  = tracker.cols_used();
        rows  = tracker.rows_used();
        cells = cols * rows;
        total = cells + cols + 1;
        if (stop_words >= 0 && stop_words < total) begin
            total = stop_words;
        end
        pause_at = pause ? $urandom_range(0, total) : -1;
        if (cols > widest) begin
            widest = cols;
        end
        if (rows > tallest) begin
            tallest = rows;
        end
        for (int k = 0; k < total; k++) begin
            if (k == pause_at) begin
                wait_idle();
            end
            if (k < cells) begin
                drain = ($urandom_range(0, 99) < 4);
            end else begin
                drain = ($urandom_range(0, 99) < 70);
            end
            send_word(drain, cell_pick(match_pct));
        end
        words_sent += total;
        frames++;
    endtask

    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        int  start_words;
        bit  misaligned;
        bit  broken;
        tracker      = new();
        calm         = 1'b0;
        words_sent   = 0;
        frames       = 0;
        widest       = 0;
        tallest      = 0;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = CFG_GRID_COLS;
        i_cfg_wdata  = '0;
        i_in_valid   = 1'b0;
        i_drain      = 1'b0;
        i_cell_value = '0;
        i_out_ready  = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset configuration: a single cell, then flush words, one of them not flagged as drain.
        send_word(1'b0, 16'h0000);
        send_word(1'b1, 16'h0000);
        send_word(1'b0, 16'h0000);

        // Full 3x3 of matches around a drain word inside the grid.
        wait_idle();
        load_reg(CFG_TARGET, 16'hFFFF);
        load_reg(CFG_GRID_COLS, 16'd3);
        load_reg(CFG_GRID_ROWS, 16'd3);
        finish_writes();
        for (int k = 0; k < 9; k++) begin
            send_word(k == 4, 16'hFFFF);
        end
        for (int k = 0; k < 4; k++) begin
            send_word(1'b1, 16'h0000);
        end

        wait_idle();
        load_reg(CFG_MODE, MODE_VON_NEUMANN);
        load_reg(CFG_TARGET, 16'h0000);
        load_reg(CFG_GRID_COLS, 16'd2);
        load_reg(CFG_GRID_ROWS, 16'd2);
        finish_writes();
        for (int k = 0; k < 4; k++) begin
            send_word(1'b0, (k == 1) ? 16'hFFFF : 16'h0000);
        end
        for (int k = 0; k < 3; k++) begin
            send_word(1'b1, 16'h0000);
        end
        words_sent += 23;
        frames     += 3;

        // Size extremes, including register values above the maximum.
        wait_idle();
        load_reg(CFG_GRID_COLS, 16'hF801);
        load_reg(CFG_GRID_ROWS, 16'hFFFF);
        load_reg(CFG_MODE, 16'h8001);
        load_reg(CFG_TARGET, 16'h5A5A);
        finish_writes();
        run_frame(-1, 50, 1'b1);

        start_words = words_sent;
        misaligned  = 1'b1;
        while (words_sent - start_words < RANDOM_WORDS) begin
            calm = (words_sent - start_words >= CALM_FROM) &&
                   (words_sent - start_words < CALM_TO);
            if (misaligned || $urandom_range(0, 99) < 60) begin
                wait_idle();
                if (misaligned || $urandom_range(0, 99) < 70) begin
                    load_reg(CFG_GRID_COLS, size_pick());
                end
                if (misaligned || $urandom_range(0, 99) < 60) begin
                    load_reg(CFG_GRID_ROWS, size_pick());
                end
                if ($urandom_range(0, 99) < 50) begin
                    load_reg(CFG_TARGET, target_pick());
                end
                if ($urandom_range(0, 99) < 40) begin
                    load_reg(CFG_MODE, CFG_DATA_W'($urandom));
                end
                finish_writes();
            end
            broken = ($urandom_range(0, 99) < 8);
            run_frame(broken ? $urandom_range(0, tracker.cols_used() * (tracker.rows_used() + 1))
                             : -1,
                      $urandom_range(20, 80), $urandom_range(0, 99) < 5);
            misaligned = broken;
        end
        calm = 1'b0;

        wait_idle();
        $display("Covered %0d words in %0d frames up to %0d columns and %0d rows, both modes.",
                 words_sent, frames, widest, tallest);
        $display("Checked %0d counts, %0d mismatches.", tracker.checked, tracker.errors);
        if (tracker.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/gnmc_pkg.sv
rtl/gnmc_ram.sv
rtl/gnmc_ctrl.sv
rtl/gnmc_stencil.sv
rtl/grid_neighbor_match_count_top.sv
bench/grid_neighbor_match_count_top_test.sv
